### design/rfx_pkg.sv
// ----------------------------------------------------------------------------
// Ring frame extractor package
// Shared widths, codes and constants of the receive ring frame extractor.
// ----------------------------------------------------------------------------
package rfx_pkg;

   localparam int BYTE_W      = 8;
   localparam int COUNT_W     = 16;
   localparam int LAG_W       = 7;
   localparam int SID_W       = 3;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 7;
   localparam int FRAME_MAX   = 4;
   localparam int FRAME_IDX_W = 2;

   // Input function codes.
   localparam logic FUNC_BYTE = 1'b0;
   localparam logic FUNC_POLL = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_RESYNC_LAG = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_STREAM_ID  = 1'b1;

   localparam logic [LAG_W-1:0]   LAG_RESET = 7'd30;
   localparam logic [SID_W-1:0]   SID_RESET = 3'd0;

   localparam logic [BYTE_W-1:0]  CONSUMED    = 8'd255;
   localparam logic [BYTE_W:0]    HEADER_BASE = 9'd250;
   localparam logic [COUNT_W-1:0] COUNT_MAX   = 16'd65500;

endpackage

### design/rfx_if.sv
// ----------------------------------------------------------------------------
// Ring frame extractor channels
// Request and response channels with valid/ready handshake and payload.
// ----------------------------------------------------------------------------
interface rfx_req_if;
   logic                       valid;
   logic                       ready;
   logic                       func;
   logic [rfx_pkg::BYTE_W-1:0] rx_byte;

   modport source (output valid, output func, output rx_byte, input ready);
   modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

interface rfx_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        frame_found;
   logic [rfx_pkg::BYTE_W-1:0]  payload0;
   logic [rfx_pkg::BYTE_W-1:0]  payload1;
   logic [rfx_pkg::BYTE_W-1:0]  payload2;
   logic [rfx_pkg::BYTE_W-1:0]  payload3;
   logic [rfx_pkg::COUNT_W-1:0] stall_total;
   logic [rfx_pkg::COUNT_W-1:0] overrun_total;

   modport source (output valid, output frame_found, output payload0, output payload1,
                   output payload2, output payload3, output stall_total,
                   output overrun_total, input ready);
   modport sink   (input valid, input frame_found, input payload0, input payload1,
                   input payload2, input payload3, input stall_total,
                   input overrun_total, output ready);
endinterface

### design/rfx_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rfx_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

### design/ring_frame_extractor_top.sv
// ----------------------------------------------------------------------------
// Ring frame extractor
// Receive ring with poll-driven frame extraction, stall and overrun counting.
// ----------------------------------------------------------------------------
// Byte arrival: written straight into the ring memory.
// Poll: a check of the read slot, then a scan in which each scanned and each payload
// byte takes a read and a write-back, then the result.
// One item is in work at a time; the next is taken once the result is registered.
// After reset a clearing pass zeroes the ring before any transfer is accepted;
// configuration writes are taken throughout.
module ring_frame_extractor_top #(
   parameter int RING_DEPTH  = 128,
   parameter int FRAME_BYTES = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   rfx_req_if.sink                         req_chan,
   rfx_rsp_if.source                       rsp_chan,
   input  logic                            csr_wr_en,
   input  logic [rfx_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rfx_pkg::CSR_DATA_W-1:0]  csr_wr_data
);

   localparam int PTR_W      = $clog2(RING_DEPTH);
   localparam int STEP_LIMIT = 4 * RING_DEPTH + 16;
   localparam int STEP_W     = $clog2(STEP_LIMIT + 1);
   localparam logic [PTR_W-1:0] LAST_POS = PTR_W'(RING_DEPTH - 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_SCAN_TEST,
      ST_SCAN_EVAL,
      ST_FRAME_READ,
      ST_FRAME_EVAL,
      ST_DONE
   } state_type;

   function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
      return (p == LAST_POS) ? '0 : p + 1'b1;
   endfunction

   // Forward distance from one ring position to another.
   function automatic logic [PTR_W-1:0] ring_dist(input logic [PTR_W-1:0] to_pos,
                                                  input logic [PTR_W-1:0] from_pos);
      logic [PTR_W:0] sum;
      sum = {1'b0, to_pos} + (PTR_W+1)'(RING_DEPTH) - {1'b0, from_pos};
      if (to_pos >= from_pos) begin
         sum = {1'b0, to_pos} - {1'b0, from_pos};
      end
      return sum[PTR_W-1:0];
   endfunction

   // The lag reduced into ring range by at most eight subtractions of RING_DEPTH.
   function automatic logic [PTR_W-1:0] lag_mod(input logic [rfx_pkg::LAG_W-1:0] lag);
      logic [rfx_pkg::LAG_W-1:0] v;
      v = lag;
      for (int k = 0; k < 8; k++) begin
         if (int'(v) >= RING_DEPTH) begin
            v = v - rfx_pkg::LAG_W'(RING_DEPTH);
         end
      end
      return PTR_W'(v);
   endfunction

   function automatic logic [rfx_pkg::COUNT_W-1:0] sat_inc(
      input logic [rfx_pkg::COUNT_W-1:0] c);
      return (c >= rfx_pkg::COUNT_MAX) ? rfx_pkg::COUNT_MAX : c + 1'b1;
   endfunction

   state_type                       state_ff, state_in;
   logic [PTR_W-1:0]                wp_ff, wp_in;
   logic [PTR_W-1:0]                rd_ff, rd_in;
   logic [PTR_W-1:0]                prev_wp_ff, prev_wp_in;
   logic [PTR_W-1:0]                clr_ff, clr_in;
   logic [rfx_pkg::COUNT_W-1:0]     stall_ff, stall_in;
   logic [rfx_pkg::COUNT_W-1:0]     overrun_ff, overrun_in;
   logic [rfx_pkg::BYTE_W-1:0]      hold_ff [rfx_pkg::FRAME_MAX];
   logic [rfx_pkg::BYTE_W-1:0]      hold_in [rfx_pkg::FRAME_MAX];
   logic [rfx_pkg::LAG_W-1:0]       lag_ff, lag_in;
   logic [rfx_pkg::SID_W-1:0]       sid_ff, sid_in;
   logic [STEP_W-1:0]               steps_ff, steps_in;
   logic [rfx_pkg::FRAME_IDX_W-1:0] fidx_ff, fidx_in;
   logic                            found_ff, found_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_found_ff, rsp_found_in;
   logic [rfx_pkg::BYTE_W-1:0]      rsp_pay_ff [rfx_pkg::FRAME_MAX];
   logic [rfx_pkg::BYTE_W-1:0]      rsp_pay_in [rfx_pkg::FRAME_MAX];
   logic [rfx_pkg::COUNT_W-1:0]     rsp_stall_ff, rsp_stall_in;
   logic [rfx_pkg::COUNT_W-1:0]     rsp_overrun_ff, rsp_overrun_in;

   logic                            ram_we;
   logic [PTR_W-1:0]                ram_wr_addr;
   logic [rfx_pkg::BYTE_W-1:0]      ram_wr_data;
   logic                            ram_re;
   logic [PTR_W-1:0]                ram_rd_addr;
   logic [rfx_pkg::BYTE_W-1:0]      ram_rd_data;

   logic                            req_xfer;
   logic [rfx_pkg::BYTE_W:0]        header;
   logic [PTR_W-1:0]                pend_dist;
   logic [rfx_pkg::LAG_W-2:0]       half_lag;

   rfx_ram #(
      .WIDTH (rfx_pkg::BYTE_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_re),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign header         = rfx_pkg::HEADER_BASE + (rfx_pkg::BYTE_W+1)'(sid_ff);
   assign pend_dist      = ring_dist(wp_ff, rd_ff);
   assign half_lag       = lag_ff[rfx_pkg::LAG_W-1:1];

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.frame_found   = rsp_found_ff;
   assign rsp_chan.payload0      = rsp_pay_ff[0];
   assign rsp_chan.payload1      = rsp_pay_ff[1];
   assign rsp_chan.payload2      = rsp_pay_ff[2];
   assign rsp_chan.payload3      = rsp_pay_ff[3];
   assign rsp_chan.stall_total   = rsp_stall_ff;
   assign rsp_chan.overrun_total = rsp_overrun_ff;

   always_comb begin
      state_in       = state_ff;
      wp_in          = wp_ff;
      rd_in          = rd_ff;
      prev_wp_in     = prev_wp_ff;
      clr_in         = clr_ff;
      stall_in       = stall_ff;
      overrun_in     = overrun_ff;
      hold_in        = hold_ff;
      lag_in         = lag_ff;
      sid_in         = sid_ff;
      steps_in       = steps_ff;
      fidx_in        = fidx_ff;
      found_in       = found_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_found_in   = rsp_found_ff;
      rsp_pay_in     = rsp_pay_ff;
      rsp_stall_in   = rsp_stall_ff;
      rsp_overrun_in = rsp_overrun_ff;
      ram_we         = 1'b0;
      ram_wr_addr    = rd_ff;
      ram_wr_data    = rfx_pkg::CONSUMED;
      ram_re         = 1'b0;
      ram_rd_addr    = rd_ff;

      if (csr_wr_en) begin
         unique case (csr_index)
            rfx_pkg::CSR_RESYNC_LAG: lag_in = csr_wr_data;
            rfx_pkg::CSR_STREAM_ID:  sid_in = csr_wr_data[rfx_pkg::SID_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we      = 1'b1;
            ram_wr_addr = clr_ff;
            ram_wr_data = '0;
            clr_in      = clr_ff + 1'b1;
            if (clr_ff == LAST_POS) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_chan.func == rfx_pkg::FUNC_BYTE) begin
                  ram_we      = 1'b1;
                  ram_wr_addr = wp_ff;
                  ram_wr_data = req_chan.rx_byte;
                  wp_in       = wrap_inc(wp_ff);
               end else begin
                  // The intact-reader test looks at the read slot, or at the slot
                  // after the writer when the two positions meet.
                  ram_re      = 1'b1;
                  ram_rd_addr = (wp_ff != rd_ff) ? rd_ff : wrap_inc(wp_ff);
                  state_in    = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            steps_in = '0;
            found_in = 1'b0;
            if (ram_rd_data == rfx_pkg::CONSUMED) begin
               if (wp_ff != rd_ff && wp_ff != prev_wp_ff) begin
                  stall_in = '0;
               end else begin
                  stall_in = sat_inc(stall_ff);
               end
            end else begin
               overrun_in = sat_inc(overrun_ff);
               rd_in      = ring_dist(wp_ff, lag_mod(lag_ff));
            end
            state_in = ST_SCAN_TEST;
         end
         ST_SCAN_TEST: begin
            if (int'(steps_ff) >= STEP_LIMIT ||
                int'(pend_dist) <= int'(half_lag)) begin
               state_in = ST_DONE;
            end else begin
               steps_in    = steps_ff + 1'b1;
               rd_in       = wrap_inc(rd_ff);
               ram_re      = 1'b1;
               ram_rd_addr = wrap_inc(rd_ff);
               state_in    = ST_SCAN_EVAL;
            end
         end
         ST_SCAN_EVAL: begin
            ram_we = 1'b1;
            if ({1'b0, ram_rd_data} == header) begin
               fidx_in  = '0;
               state_in = ST_FRAME_READ;
            end else begin
               state_in = ST_SCAN_TEST;
            end
         end
         ST_FRAME_READ: begin
            rd_in       = wrap_inc(rd_ff);
            ram_re      = 1'b1;
            ram_rd_addr = wrap_inc(rd_ff);
            state_in    = ST_FRAME_EVAL;
         end
         ST_FRAME_EVAL: begin
            ram_we           = 1'b1;
            hold_in[fidx_ff] = ram_rd_data;
            if (fidx_ff == rfx_pkg::FRAME_IDX_W'(FRAME_BYTES - 1)) begin
               found_in = 1'b1;
               // Stop after a frame unless at least half the ring is pending.
               if (int'(pend_dist) < RING_DEPTH / 2) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SCAN_TEST;
               end
            end else begin
               fidx_in  = fidx_ff + 1'b1;
               state_in = ST_FRAME_READ;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               prev_wp_in     = wp_ff;
               rsp_valid_in   = 1'b1;
               rsp_found_in   = found_ff;
               rsp_pay_in     = hold_ff;
               rsp_stall_in   = stall_ff;
               rsp_overrun_in = overrun_ff;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         wp_ff        <= '0;
         rd_ff        <= '0;
         prev_wp_ff   <= '0;
         clr_ff       <= '0;
         stall_ff     <= '0;
         overrun_ff   <= '0;
         hold_ff      <= '{default: '0};
         lag_ff       <= rfx_pkg::LAG_RESET;
         sid_ff       <= rfx_pkg::SID_RESET;
         steps_ff     <= '0;
         fidx_ff      <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         rd_ff        <= rd_in;
         prev_wp_ff   <= prev_wp_in;
         clr_ff       <= clr_in;
         stall_ff     <= stall_in;
         overrun_ff   <= overrun_in;
         hold_ff      <= hold_in;
         lag_ff       <= lag_in;
         sid_ff       <= sid_in;
         steps_ff     <= steps_in;
         fidx_ff      <= fidx_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_found_ff   <= rsp_found_in;
      rsp_pay_ff     <= rsp_pay_in;
      rsp_stall_ff   <= rsp_stall_in;
      rsp_overrun_ff <= rsp_overrun_in;
   end

   // The ring memory is never read and written in the same cycle, so no
   // forwarding between its ports is needed.
   a_no_port_overlap: assert property (@(posedge clock) disable iff (reset)
      !(ram_we && ram_re))
      else $error("ring memory read and write in the same cycle");

   a_counts_saturate: assert property (@(posedge clock) disable iff (reset)
      stall_ff <= rfx_pkg::COUNT_MAX && overrun_ff <= rfx_pkg::COUNT_MAX)
      else $error("stall or overrun count beyond saturation");

   a_poll_starts_check: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_chan.func == rfx_pkg::FUNC_POLL |=> state_ff == ST_CHECK)
      else $error("poll transfer did not start the ring check");

   a_frame_index_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FRAME_READ || state_ff == ST_FRAME_EVAL) |->
         int'(fidx_ff) < FRAME_BYTES)
      else $error("frame byte index beyond frame length");

endmodule

### tb/ring_frame_extractor_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ring frame extractor testbench
// Streams byte arrivals and polls into the extractor and keeps its own image
// of the receive ring, read and write positions, counters and held frame.
// Every poll result is checked field by field against that image, under
// random idling on both channels, a long result hold-off and several
// register settings.
// ----------------------------------------------------------------------------
module ring_frame_extractor_top_tb;

   localparam int RING_DEPTH    = 128;
   localparam int FRAME_BYTES   = 4;
   localparam int PTR_W         = $clog2(RING_DEPTH);
   localparam int SETTLE_CYCLES = 20;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS   = 180;

   typedef struct packed {
      logic                                found;
      logic [rfx_pkg::FRAME_MAX-1:0][7:0]  payload;
      logic [rfx_pkg::COUNT_W-1:0]         stalls;
      logic [rfx_pkg::COUNT_W-1:0]         overruns;
   } poll_result_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            csr_wr_en = 1'b0;
   logic [rfx_pkg::CSR_IDX_W-1:0]   csr_index = '0;
   logic [rfx_pkg::CSR_DATA_W-1:0]  csr_wr_data = '0;

   rfx_req_if req_chan ();
   rfx_rsp_if rsp_chan ();

   ring_frame_extractor_top #(
      .RING_DEPTH  (RING_DEPTH),
      .FRAME_BYTES (FRAME_BYTES)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // Image of the block's state.
   logic [rfx_pkg::BYTE_W-1:0]           ring_img [RING_DEPTH];
   logic [PTR_W-1:0]                     wr_ptr;
   logic [PTR_W-1:0]                     rd_ptr;
   logic [PTR_W-1:0]                     last_wr_ptr;
   int unsigned                          stall_cnt;
   int unsigned                          overrun_cnt;
   logic [rfx_pkg::FRAME_MAX-1:0][7:0]   held;
   logic [rfx_pkg::LAG_W-1:0]            lag_cfg;
   logic [rfx_pkg::SID_W-1:0]            sid_cfg;

   poll_result_type pending_polls [$];
   int unsigned     items_sent  = 0;
   int unsigned     error_count = 0;
   bit              idle_on     = 1'b1;
   int unsigned     hold_cycles = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [PTR_W-1:0] ring_gap(input logic [PTR_W-1:0] to,
                                                 input logic [PTR_W-1:0] from);
      return to - from;
   endfunction

   function automatic void clear_ring_image();
      int k;
      for (k = 0; k < RING_DEPTH; k++) ring_img[k] = '0;
      wr_ptr      = '0;
      rd_ptr      = '0;
      last_wr_ptr = '0;
      stall_cnt   = 0;
      overrun_cnt = 0;
      held        = '0;
      lag_cfg     = rfx_pkg::LAG_RESET;
      sid_cfg     = rfx_pkg::SID_RESET;
   endfunction

   // Applies one accepted item to the image; a poll queues its result.
   function automatic void predict_ring_item(input logic fn,
                                             input logic [rfx_pkg::BYTE_W-1:0] data);
      logic [PTR_W-1:0] rd;
      logic [PTR_W-1:0] ahead;
      int unsigned      half_lag;
      int unsigned      hdr;
      int unsigned      steps;
      int               k;
      bit               found;
      bit               done;
      poll_result_type  res;

      if (fn == rfx_pkg::FUNC_BYTE) begin
         ring_img[wr_ptr] = data;
         wr_ptr = wr_ptr + 1'b1;
         return;
      end

      rd    = rd_ptr;
      ahead = wr_ptr + 1'b1;
      if (wr_ptr != rd) begin
         if (ring_img[rd] == rfx_pkg::CONSUMED) begin
            if (wr_ptr != last_wr_ptr) stall_cnt = 0;
            else stall_cnt++;
         end else begin
            overrun_cnt++;
            rd = wr_ptr - lag_cfg;
         end
      end else begin
         // The reader sits on the write position: it either caught up or was lapped.
         if (ring_img[ahead] == rfx_pkg::CONSUMED) begin
            stall_cnt++;
         end else begin
            overrun_cnt++;
            rd = wr_ptr - lag_cfg;
         end
      end
      if (stall_cnt > rfx_pkg::COUNT_MAX) stall_cnt = 32'(rfx_pkg::COUNT_MAX);
      if (overrun_cnt > rfx_pkg::COUNT_MAX) overrun_cnt = 32'(rfx_pkg::COUNT_MAX);

      half_lag = 32'(lag_cfg) / 2;
      hdr      = 32'(rfx_pkg::HEADER_BASE) + 32'(sid_cfg);
      steps    = 0;
      found    = 1'b0;
      done     = 1'b0;
      while (!done && steps < 4 * RING_DEPTH + 16) begin
         steps++;
         if (ring_gap(wr_ptr, rd) <= half_lag) begin
            done = 1'b1;
         end else begin
            rd = rd + 1'b1;
            if (ring_img[rd] == hdr) begin
               ring_img[rd] = rfx_pkg::CONSUMED;
               for (k = 0; k < FRAME_BYTES; k++) begin
                  rd = rd + 1'b1;
                  held[k] = ring_img[rd];
                  ring_img[rd] = rfx_pkg::CONSUMED;
               end
               found = 1'b1;
               if (ring_gap(wr_ptr, rd) < RING_DEPTH / 2) done = 1'b1;
            end else begin
               ring_img[rd] = rfx_pkg::CONSUMED;
            end
         end
      end

      rd_ptr      = rd;
      last_wr_ptr = wr_ptr;

      res.found    = found;
      res.payload  = held;
      res.stalls   = stall_cnt[rfx_pkg::COUNT_W-1:0];
      res.overruns = overrun_cnt[rfx_pkg::COUNT_W-1:0];
      pending_polls.push_back(res);
   endfunction

   task automatic report_mismatch(input string what, input int unsigned want,
                                  input int unsigned got);
      $display("%0t ns: mismatch on %s: expected %0d, got %0d", $time, what, want, got);
      error_count++;
   endtask

   task automatic check_field(input string what, input int unsigned want,
                              input int unsigned got);
      if (want != got) report_mismatch(what, want, got);
   endtask

   always @(posedge clock) begin : poll_checker
      poll_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_polls.size() == 0) begin
            report_mismatch("result with no poll pending", 0, 1);
         end else begin
            want = pending_polls.pop_front();
            check_field("frame_found", 32'(want.found), 32'(rsp_chan.frame_found));
            check_field("payload0", 32'(want.payload[0]), 32'(rsp_chan.payload0));
            check_field("payload1", 32'(want.payload[1]), 32'(rsp_chan.payload1));
            check_field("payload2", 32'(want.payload[2]), 32'(rsp_chan.payload2));
            check_field("payload3", 32'(want.payload[3]), 32'(rsp_chan.payload3));
            check_field("stall_total", 32'(want.stalls), 32'(rsp_chan.stall_total));
            check_field("overrun_total", 32'(want.overruns),
                        32'(rsp_chan.overrun_total));
         end
      end
   end

   // Result side: a random stall before each transfer, or a long hold-off on request.
   initial begin : result_sink
      int unsigned pause;
      rsp_chan.ready = 1'b0;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (hold_cycles != 0) begin
            pause = hold_cycles;
            hold_cycles = 0;
         end else begin
            pause = idle_on ? $urandom_range(0, 3) : 0;
         end
         if (pause != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (pause) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock);
         while (!(rsp_chan.valid && rsp_chan.ready) && hold_cycles == 0);
      end
   end

   // Offers one item and returns at the edge of its transfer, valid still high.
   task automatic send_item(input logic fn, input logic [rfx_pkg::BYTE_W-1:0] data);
      int unsigned gap;
      gap = idle_on ? $urandom_range(0, 3) : 0;
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.func    <= fn;
      req_chan.rx_byte <= data;
      do @(posedge clock); while (!req_chan.ready);
      predict_ring_item(fn, data);
      items_sent++;
   endtask

   // Stops offering and waits until every poll result has come back.
   task automatic settle();
      req_chan.valid <= 1'b0;
      while (pending_polls.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [rfx_pkg::CSR_IDX_W-1:0] idx,
                            input logic [rfx_pkg::CSR_DATA_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(posedge clock);
      if (idx == rfx_pkg::CSR_RESYNC_LAG) lag_cfg = value[rfx_pkg::LAG_W-1:0];
      else sid_cfg = value[rfx_pkg::SID_W-1:0];
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [rfx_pkg::BYTE_W-1:0] header_byte();
      return rfx_pkg::BYTE_W'(rfx_pkg::HEADER_BASE + sid_cfg);
   endfunction

   function automatic logic [rfx_pkg::BYTE_W-1:0] payload_byte();
      int unsigned pick;
      pick = $urandom_range(0, 7);
      if (pick == 0) return rfx_pkg::CONSUMED;
      if (pick == 1) return header_byte();
      return rfx_pkg::BYTE_W'($urandom_range(0, 255));
   endfunction

   function automatic logic [rfx_pkg::BYTE_W-1:0] random_byte();
      return rfx_pkg::BYTE_W'($urandom_range(0, 255));
   endfunction

   task automatic send_frame();
      int k;
      send_item(rfx_pkg::FUNC_BYTE, header_byte());
      for (k = 0; k < FRAME_BYTES; k++) send_item(rfx_pkg::FUNC_BYTE, payload_byte());
   endtask

   task automatic send_noise(input int unsigned count);
      repeat (count) send_item(rfx_pkg::FUNC_BYTE, random_byte());
   endtask

   // A long run of frames and noise, enough to lap the reader.
   task automatic send_mixed(input int unsigned count);
      int unsigned start;
      start = items_sent;
      while (items_sent - start < count) begin
         if ($urandom_range(0, 3) != 0) send_frame();
         else send_noise($urandom_range(1, 3));
      end
   endtask

   task automatic test_first_polls();
      // The zero ring after reset reads as an overrun, the next poll as a stall.
      send_item(rfx_pkg::FUNC_POLL, 8'h00);
      send_item(rfx_pkg::FUNC_POLL, 8'hFF);
      settle();
   endtask

   task automatic test_frame_capture();
      write_reg(rfx_pkg::CSR_RESYNC_LAG, '0);
      send_item(rfx_pkg::FUNC_BYTE, header_byte());
      send_item(rfx_pkg::FUNC_BYTE, 8'h00);
      send_item(rfx_pkg::FUNC_BYTE, 8'hFF);
      send_item(rfx_pkg::FUNC_BYTE, 8'h7F);
      send_item(rfx_pkg::FUNC_BYTE, 8'h80);
      send_item(rfx_pkg::FUNC_POLL, 8'h00);
      send_item(rfx_pkg::FUNC_POLL, 8'h00);
      send_item(rfx_pkg::FUNC_POLL, 8'h00);
      settle();
   endtask

   task automatic test_stream_ids();
      write_reg(rfx_pkg::CSR_STREAM_ID, 7'd4);
      send_frame();
      send_item(rfx_pkg::FUNC_POLL, 8'h00);
      settle();
      // With identifier five the header equals a consumed byte.
      write_reg(rfx_pkg::CSR_STREAM_ID, 7'd5);
      send_noise(3);
      send_item(rfx_pkg::FUNC_POLL, 8'h00);
      settle();
      // With identifier seven the header lies beyond a byte and never matches.
      write_reg(rfx_pkg::CSR_STREAM_ID, 7'd7);
      send_item(rfx_pkg::FUNC_BYTE, 8'd250);
      send_item(rfx_pkg::FUNC_BYTE, 8'd255);
      send_item(rfx_pkg::FUNC_POLL, 8'h00);
      settle();
   endtask

   task automatic test_result_backpressure();
      write_reg(rfx_pkg::CSR_RESYNC_LAG, 7'd4);
      write_reg(rfx_pkg::CSR_STREAM_ID, 7'd2);
      idle_on = 1'b1;
      hold_cycles = 200;
      repeat (12) begin
         send_frame();
         send_item(rfx_pkg::FUNC_POLL, random_byte());
      end
      settle();
   endtask

   task automatic test_random_traffic();
      int unsigned phase;
      int unsigned goal;
      int unsigned pick;
      logic [rfx_pkg::LAG_W-1:0] lag;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         unique case (phase)
            0: lag = '0;
            1: lag = '1;
            2: lag = 7'd1;
            default: lag = rfx_pkg::LAG_W'($urandom_range(0, 127));
         endcase
         write_reg(rfx_pkg::CSR_RESYNC_LAG, lag);
         write_reg(rfx_pkg::CSR_STREAM_ID, rfx_pkg::CSR_DATA_W'(phase % 5));
         idle_on = (phase != 2) && (phase != 5);
         goal = items_sent + PHASE_ITEMS;
         while (items_sent < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
               repeat ($urandom_range(1, 3)) send_frame();
               if ($urandom_range(0, 3) == 0) send_noise($urandom_range(1, 4));
            end else if (pick < 75) begin
               send_mixed($urandom_range(40, 140));
            end else if (pick < 85) begin
               // Truncated frame.
               send_item(rfx_pkg::FUNC_BYTE, header_byte());
               send_noise($urandom_range(0, 3));
            end else if (pick < 92) begin
               send_noise($urandom_range(1, 8));
            end
            send_item(rfx_pkg::FUNC_POLL, random_byte());
         end
         settle();
      end
   endtask

   initial begin
      req_chan.valid   = 1'b0;
      req_chan.func    = rfx_pkg::FUNC_BYTE;
      req_chan.rx_byte = '0;
      clear_ring_image();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_first_polls();
      test_frame_capture();
      test_stream_ids();
      test_result_backpressure();
      test_random_traffic();

      settle();
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
